// File: sv/sle_pkg.sv
// shared types, codes and constants of the sorted list engine
package sle_pkg;

  localparam int SLE_CAPACITY = 64;
  localparam int SLE_DATA_W   = 32;
  localparam int SLE_FUNC_W   = 2;
  localparam int SLE_STAT_W   = 2;
  localparam int SLE_CNT_OUT_W = 7;

  typedef enum logic [SLE_FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_DELETE = 2'd2
  } sle_func_t;

  typedef enum logic [SLE_STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } sle_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } sle_state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                         cmp;
    logic                         ins;
    logic                         del;
    logic signed [SLE_DATA_W-1:0] key;
  } sle_ctrl_t;

endpackage

// File: sv/sorted_list_engine_core.sv
// top level of the sorted list engine: controller, cell chain and result register
//
// keeps up to CAPACITY signed 32-bit values in ascending order, duplicates
// allowed, one value per cell in a chain of identical cells. func 0 inserts
// value before the first entry that is not smaller (status full when the list
// is at capacity), func 1 returns how many entries equal value, func 2 removes
// the first entry equal to value (status not found or empty otherwise); func 3
// does nothing and reports ok. every item gives exactly one result carrying the
// fill level after the operation. an item is accepted in idle, then every cell
// compares its entry against the broadcast key in the compare state, then in
// the update state the cells shift toward or away from their neighbors and the
// result is written. in_stall is high in the compare and update states, so a
// new item waits until the last is updated; the update waits while a previous
// result still sits stalled in the output register. a new item is taken while a
// finished result waits downstream. no clearing pass after reset.
module sorted_list_engine_core
  import sle_pkg::*;
#(
  parameter int CAPACITY = SLE_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SLE_FUNC_W-1:0]           in_func,
  input  logic signed [SLE_DATA_W-1:0]    in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [SLE_STAT_W-1:0]           out_status,
  output logic [SLE_CNT_OUT_W-1:0]        out_match_count,
  output logic [SLE_CNT_OUT_W-1:0]        out_fill_level
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // sequencer state
  sle_state_t                   state_r;
  sle_state_t                   state_nxt;
  logic [SLE_FUNC_W-1:0]        func_r;
  logic signed [SLE_DATA_W-1:0] key_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;

  // result register
  logic                         out_valid_r;
  logic [SLE_STAT_W-1:0]        status_r;
  logic [SLE_STAT_W-1:0]        status_nxt;
  logic [SLE_CNT_OUT_W-1:0]     match_r;
  logic [SLE_CNT_OUT_W-1:0]     match_nxt;
  logic [SLE_CNT_OUT_W-1:0]     fill_r;

  // chain wiring
  logic signed [SLE_DATA_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]          valid_w;
  logic [CAPACITY-1:0]          place_w;
  logic [CAPACITY-1:0]          ge_w;
  logic [CAPACITY-1:0]          gt_w;
  logic [CNT_W-1:0]             hits;

  sle_ctrl_t ctrl;
  logic      in_take;
  logic      fire;
  logic      full;
  logic      empty;
  logic      do_ins;
  logic      do_del;

  assign in_take = in_valid && !in_stall;
  // the update cycle may only finish when the result register can take the result
  assign fire    = (state_r == ST_UPD) && !(out_valid_r && out_stall);
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  if (fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: stall, broadcast and result
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    do_ins     = 1'b0;
    do_del     = 1'b0;
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    match_nxt  = '0;
    unique case (func_r)
      FN_INSERT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FN_SEARCH: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else if (hits == '0) begin
          status_nxt = STAT_NOT_FOUND;
        end else begin
          match_nxt = SLE_CNT_OUT_W'(hits);
        end
      end
      FN_DELETE: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else if (hits == '0) begin
          status_nxt = STAT_NOT_FOUND;
        end else begin
          do_del    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        // unused code leaves the list alone
      end
    endcase
    ctrl.cmp = (state_r == ST_CMP);
    ctrl.ins = fire && do_ins;
    ctrl.del = fire && do_del;
    ctrl.key = key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r <= in_func;
      key_r  <= in_value;
    end
    if (fire) begin
      status_r <= status_nxt;
      match_r  <= match_nxt;
      fill_r   <= SLE_CNT_OUT_W'(count_nxt);
    end
  end

  // chain of cells; the ends see an always-valid left edge and an empty right edge
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [SLE_DATA_W-1:0] l_entry;
    logic                         l_valid;
    logic                         l_place;
    logic signed [SLE_DATA_W-1:0] r_entry;
    logic                         r_valid;

    if (i == 0) begin : g_head
      assign l_entry = key_r;
      assign l_valid = 1'b1;
      assign l_place = 1'b0;
    end else begin : g_body
      assign l_entry = entry_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_place = place_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_entry = key_r;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_entry = entry_w[i+1];
      assign r_valid = valid_w[i+1];
    end

    sle_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .left_place  (l_place),
      .right_entry (r_entry),
      .right_valid (r_valid),
      .entry       (entry_w[i]),
      .valid       (valid_w[i]),
      .place       (place_w[i]),
      .ge          (ge_w[i]),
      .gt          (gt_w[i])
    );
  end

  // number of entries equal to the key, from the registered flags
  sle_count #(
    .CAPACITY (CAPACITY)
  ) u_count (
    .ge   (ge_w),
    .gt   (gt_w),
    .fill (count_r),
    .hits (hits)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_match_count = match_r;
  assign out_fill_level  = fill_r;

endmodule

// File: sv/sle_cell.sv
// one storage cell of the sorted chain: entry, valid bit and compare flags
module sle_cell
  import sle_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  sle_ctrl_t                    ctrl,
  input  logic signed [SLE_DATA_W-1:0] left_entry,
  input  logic                         left_valid,
  input  logic                         left_place,
  input  logic signed [SLE_DATA_W-1:0] right_entry,
  input  logic                         right_valid,
  output logic signed [SLE_DATA_W-1:0] entry,
  output logic                         valid,
  output logic                         place,
  output logic                         ge,
  output logic                         gt
);

  logic signed [SLE_DATA_W-1:0] entry_r;
  logic                         valid_r;
  logic                         ge_r;
  logic                         gt_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.ins) begin
      valid_r <= valid_r | left_valid;
    end else if (ctrl.del) begin
      valid_r <= right_valid;
    end
  end

  // payload and flags
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      ge_r <= valid_r && (entry_r >= ctrl.key);
      gt_r <= valid_r && (entry_r > ctrl.key);
    end
    if (ctrl.ins) begin
      if (left_place) begin
        entry_r <= left_entry;
      end else if (place) begin
        entry_r <= ctrl.key;
      end
    end else if (ctrl.del && ge_r) begin
      entry_r <= right_entry;
    end
  end

  // insert point: first cell that is empty or not smaller than the key
  assign place = !valid_r || ge_r;
  assign entry = entry_r;
  assign valid = valid_r;
  assign ge    = ge_r;
  assign gt    = gt_r;

endmodule

// File: sv/sle_count.sv
// turns the chain's compare flags into the number of entries equal to the key
module sle_count
  import sle_pkg::*;
#(
  parameter int CAPACITY = SLE_CAPACITY
) (
  input  logic [CAPACITY-1:0]                 ge,
  input  logic [CAPACITY-1:0]                 gt,
  input  logic [$clog2(CAPACITY+1)-1:0]       fill,
  output logic [$clog2(CAPACITY+1)-1:0]       hits
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] idx_ge;
  logic [CNT_W-1:0] idx_gt;
  logic             prev_ge;
  logic             prev_gt;

  // flags form one run at the tail of the valid prefix, so the rising edge is one-hot
  always_comb begin
    idx_ge  = '0;
    idx_gt  = '0;
    prev_ge = 1'b0;
    prev_gt = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ge[i] && !prev_ge) idx_ge = idx_ge | CNT_W'(i);
      if (gt[i] && !prev_gt) idx_gt = idx_gt | CNT_W'(i);
      prev_ge = ge[i];
      prev_gt = gt[i];
    end
  end

  assign hits = ((|gt) ? idx_gt : fill) - ((|ge) ? idx_ge : fill);

endmodule

// File: sv/sle_checker.sv
// port-level checks of the sorted list engine and their binding to the top level
module sle_checker
  import sle_pkg::*;
#(
  parameter int CAPACITY = SLE_CAPACITY
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [SLE_STAT_W-1:0]        out_status,
  input logic [SLE_CNT_OUT_W-1:0]     out_match_count,
  input logic [SLE_CNT_OUT_W-1:0]     out_fill_level
);

  // an accepted item keeps the input stalled while it is worked on
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an item");

  // a count of matches only comes with an ok status
  a_hits_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_count != '0) |-> out_status == STAT_OK)
    else $error("match count with a status other than ok");

  // full is only reported at capacity
  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> out_fill_level == SLE_CNT_OUT_W'(CAPACITY))
    else $error("full reported below capacity");

  // empty means nothing stored and nothing matched
  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |-> out_fill_level == '0 && out_match_count == '0)
    else $error("empty reported with entries");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_match_count) && $stable(out_fill_level))
    else $error("stalled result changed");

endmodule

bind sorted_list_engine_core sle_checker #(
  .CAPACITY (CAPACITY)
) u_sle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_match_count (out_match_count),
  .out_fill_level  (out_fill_level)
);
